/* rtl/nfd_pkg.sv */
// Shared types, register codes and constants of the noise floor chunk activity detector.
package nfd_pkg;

    // Default bound on words per chunk
    localparam int MAX_CHUNK_WORDS_DEF = 4096;

    // Entries of the queue between the front and the back part
    localparam int QUEUE_DEPTH = 4;

    // Threshold saturation level, 2^31
    localparam logic [31:0] SAT_LEVEL = 32'h8000_0000;

    // Register defaults
    localparam logic [23:0] SKIP_WORDS_RST  = 24'd96000;
    localparam logic [23:0] TRAIN_WORDS_RST = 24'd192000;
    localparam logic [12:0] CHUNK_WORDS_RST = 13'd4096;
    localparam logic [12:0] MIN_ACTIVE_RST  = 13'd409;
    localparam logic [15:0] GAIN_RST        = 16'd4506;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_SKIP_WORDS  = 3'd0,
        REG_TRAIN_WORDS = 3'd1,
        REG_CHUNK_WORDS = 3'd2,
        REG_MIN_ACTIVE  = 3'd3,
        REG_GAIN        = 3'd4
    } reg_index_t;

    // Configuration register set
    typedef struct packed {
        logic [23:0] skip_words;
        logic [23:0] train_words;
        logic [12:0] chunk_words;
        logic [12:0] min_active_count;
        logic [15:0] threshold_gain;
    } cfg_t;

    // One classified word handed from the front to the back part
    typedef struct packed {
        logic [31:0] mag;        // magnitude of the word, 0..2^31
        logic        is_chunk;   // 1: chunk word, 0: training word
        logic        first;      // first training word of a recording
        logic        last;       // last training word, or last word of a chunk
        logic [23:0] chunk_num;  // chunk index, meaningful with is_chunk
    } q_entry_t;

endpackage

/* rtl/nfd_front.sv */
// Front part: phase sequencing and word classification.
module nfd_front
    import nfd_pkg::*;
#(
    parameter int MAX_CHUNK_WORDS = MAX_CHUNK_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        accept,
    input  logic [31:0] sample,
    input  logic        new_recording,
    output logic        push,
    output q_entry_t    entry
);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_SKIP  = 4'b0010,
        PH_TRAIN = 4'b0100,
        PH_CHUNK = 4'b1000
    } phase_t;

    // Chunk length bound as it applies to a 13-bit register
    localparam logic [12:0] MAX_LIM =
        (MAX_CHUNK_WORDS > 8191) ? 13'd8191 : 13'(MAX_CHUNK_WORDS);

    phase_t      phase_reg, phase_next;
    logic [23:0] cnt_reg, cnt_next;
    logic [12:0] wic_reg, wic_next;
    logic [23:0] cc_reg, cc_next;

    logic [31:0] mag;
    logic [23:0] tlimit;
    logic [12:0] cw_eff;
    logic [12:0] climit;

    // Magnitude at 32 bits unsigned; the most negative word maps to 2^31
    assign mag    = sample[31] ? (32'd0 - sample) : sample;
    assign tlimit = (cfg.train_words == 24'd0) ? 24'd1 : cfg.train_words;
    assign cw_eff = (cfg.chunk_words == 13'd0) ? 13'd1 : cfg.chunk_words;
    assign climit = (cw_eff > MAX_LIM) ? MAX_LIM : cw_eff;

    // Classify the request and advance the phase counters
    always_comb
    begin
        phase_t      ph;
        logic [23:0] cnt;
        logic [23:0] tcnt1;
        logic [12:0] wic1;

        ph         = new_recording ? PH_SKIP : phase_reg;
        cnt        = new_recording ? 24'd0 : cnt_reg;
        tcnt1      = 24'd0;
        wic1       = wic_reg + 13'd1;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        wic_next   = wic_reg;
        cc_next    = cc_reg;
        push       = 1'b0;
        entry      = '0;
        entry.mag  = mag;
        entry.chunk_num = cc_reg;

        if (accept)
        begin
            if (ph == PH_SKIP && cnt < cfg.skip_words)
            begin
                // still in the glitch window
                phase_next = PH_SKIP;
                cnt_next   = cnt + 24'd1;
            end
            else if (ph == PH_SKIP || ph == PH_TRAIN)
            begin
                // training word; the first one leaves the skip phase
                tcnt1        = ((ph == PH_SKIP) ? 24'd0 : cnt) + 24'd1;
                push         = 1'b1;
                entry.first  = (ph == PH_SKIP);
                entry.last   = (tcnt1 >= tlimit);
                if (tcnt1 >= tlimit)
                begin
                    phase_next = PH_CHUNK;
                    cnt_next   = 24'd0;
                    wic_next   = 13'd0;
                    cc_next    = 24'd0;
                end
                else
                begin
                    phase_next = PH_TRAIN;
                    cnt_next   = tcnt1;
                end
            end
            else if (ph == PH_CHUNK)
            begin
                // chunk word; close the chunk at its length
                push           = 1'b1;
                entry.is_chunk = 1'b1;
                entry.last     = (wic1 >= climit);
                if (wic1 >= climit)
                begin
                    wic_next = 13'd0;
                    cc_next  = cc_reg + 24'd1;
                end
                else
                begin
                    wic_next = wic1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= 24'd0;
            wic_reg   <= 13'd0;
            cc_reg    <= 24'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            wic_reg   <= wic_next;
            cc_reg    <= cc_next;
        end
    end

endmodule

/* rtl/nfd_queue.sv */
// Short queue of classified words between the front and the back part.
module nfd_queue
    import nfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output logic     full,
    output logic     not_empty,
    output q_entry_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t           slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
        else $error("queue pop while empty");
    a_fill_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue fill level did not rise on push");

endmodule

/* rtl/nfd_back.sv */
// Back part: peak learning, threshold, loud-word counting and result register.
module nfd_back
    import nfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  q_entry_t    head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata
);

    logic [31:0] peak_reg, peak_next;
    logic [31:0] thr_reg, thr_next;
    logic        pend_reg, pend_next;
    logic [12:0] loud_reg, loud_next;
    logic        out_valid_reg, out_valid_next;
    logic        active_reg;
    logic [23:0] num_reg;
    logic [12:0] cnt_out_reg;
    logic [31:0] peak_out_reg;

    logic        closes_chunk;
    logic        emit;
    logic [47:0] prod;
    logic [35:0] scaled;
    logic [12:0] loud1;

    assign closes_chunk = head.is_chunk && head.last;
    assign pop   = q_valid && !pend_reg && (!closes_chunk || !out_valid_reg || m_tready);
    assign emit  = pop && closes_chunk;
    assign prod  = {16'd0, peak_reg} * {32'd0, cfg.threshold_gain};
    assign scaled = prod[47:12];
    assign loud1 = loud_reg + 13'((head.mag >= thr_reg) ? 1 : 0);

    // Learn the peak, set the threshold and count loud words
    always_comb
    begin
        peak_next = peak_reg;
        thr_next  = thr_reg;
        pend_next = 1'b0;
        loud_next = loud_reg;

        if (pend_reg)
        begin
            // a bubble after training: scale and saturate the learned peak
            thr_next = (scaled > {4'd0, SAT_LEVEL}) ? SAT_LEVEL : scaled[31:0];
        end
        else if (pop)
        begin
            if (!head.is_chunk)
            begin
                if (head.first || head.mag > peak_reg)
                begin
                    peak_next = head.mag;
                end
                if (head.last)
                begin
                    pend_next = 1'b1;
                    loud_next = 13'd0;
                end
            end
            else
            begin
                loud_next = head.last ? 13'd0 : loud1;
            end
        end
    end

    // Hold a result until it is taken
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg      <= 32'd0;
            thr_reg       <= 32'd0;
            pend_reg      <= 1'b0;
            loud_reg      <= 13'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            peak_reg      <= peak_next;
            thr_reg       <= thr_next;
            pend_reg      <= pend_next;
            loud_reg      <= loud_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            active_reg   <= (loud1 >= cfg.min_active_count);
            num_reg      <= head.chunk_num;
            cnt_out_reg  <= loud1;
            peak_out_reg <= peak_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, peak_out_reg, cnt_out_reg, num_reg, active_reg};

    a_bubble_once: assert property (@(posedge clk) disable iff (!rst_n) pend_reg |=> !pend_reg)
        else $error("threshold bubble lasted more than one cycle");
    a_thr_sat: assert property (@(posedge clk) disable iff (!rst_n) thr_reg <= SAT_LEVEL)
        else $error("threshold above saturation level");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(emit && out_valid_reg && !m_tready))
        else $error("result overwritten while waiting");

endmodule

/* rtl/noise_floor_chunk_activity_detector.sv */
// Top level: configuration registers, front part, queue and back part.
// Latency: with an empty queue the word that closes a chunk passes the queue slot and then the result
// register before it is on m_tvalid; each word waiting ahead of it in the queue delays it,
// and m_tready holding the result register delays it for as long as it stalls.
// Throughput: one word per cycle, but s_tready is low while the queue is full; the threshold
// multiply stalls the back part once per training end, which the four-entry queue absorbs.
// Reset: asynchronous, active low; registers take their defaults, the block idles until
// a word with new_recording set arrives. No clearing pass.
module noise_floor_chunk_activity_detector
    import nfd_pkg::*;
#(
    parameter int MAX_CHUNK_WORDS = MAX_CHUNK_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] sample
    input  logic [0:0]  s_tuser,    // [0] new_recording
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [0] chunk_active, [24:1] chunk_number,
                                    // [37:25] loud_count, [69:38] silence_peak
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wdata
);

    cfg_t     cfg_reg, cfg_next;
    logic     accept;
    logic     push;
    q_entry_t entry;
    logic     full;
    logic     q_valid;
    q_entry_t head;
    logic     pop;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SKIP_WORDS:  cfg_next.skip_words       = cfg_wdata;
                REG_TRAIN_WORDS: cfg_next.train_words      = cfg_wdata;
                REG_CHUNK_WORDS: cfg_next.chunk_words      = cfg_wdata[12:0];
                REG_MIN_ACTIVE:  cfg_next.min_active_count = cfg_wdata[12:0];
                REG_GAIN:        cfg_next.threshold_gain   = cfg_wdata[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.skip_words       <= SKIP_WORDS_RST;
            cfg_reg.train_words      <= TRAIN_WORDS_RST;
            cfg_reg.chunk_words      <= CHUNK_WORDS_RST;
            cfg_reg.min_active_count <= MIN_ACTIVE_RST;
            cfg_reg.threshold_gain   <= GAIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    nfd_front #(
        .MAX_CHUNK_WORDS (MAX_CHUNK_WORDS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .accept        (accept),
        .sample        (s_tdata),
        .new_recording (s_tuser[0]),
        .push          (push),
        .entry         (entry)
    );

    nfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (entry),
        .pop        (pop),
        .full       (full),
        .not_empty  (q_valid),
        .head       (head)
    );

    nfd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
